// ----- rtl/gpr_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the gamma pixel resolve core.
// No dependencies; imported by every module of the block.
package gpr_pkg;
   localparam int FRAC_BITS   = 16;
   localparam int COMP_W      = 28;
   localparam int POS_W       = 13;
   localparam int ADDR_W      = 12;
   localparam int LEVEL_W     = 16;
   localparam int COUNT_W     = 11;
   localparam int DIM_W       = 13;
   localparam int DQ_W        = COMP_W + FRAC_BITS;
   localparam int ROOT_W      = DQ_W / 2;
   localparam int SREM_W      = ROOT_W + 2;
   localparam int DIV_STEPS   = DQ_W;
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int CHAIN_LEN   = DIV_STEPS + SQRT_STEPS;
   localparam int OPND_W      = FRAC_BITS + 1;
   localparam int PROD_W      = LEVEL_W + OPND_W;
   localparam logic [DIM_W-1:0]  MAX_DIM   = 13'd4096;
   localparam logic [OPND_W-1:0] ONE_FX    = 17'd65536;
   localparam logic [OPND_W-1:0] CLAMP_TOP = 17'd65470;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_OUT   = 3'd1;
   localparam logic [2:0] ST_RED   = 3'd2;
   localparam logic [2:0] ST_GREEN = 3'd3;
   localparam logic [2:0] ST_BLUE  = 3'd4;

   localparam logic [2:0] REG_ANTIALIAS = 3'd0;
   localparam logic [2:0] REG_SAMPLES   = 3'd1;
   localparam logic [2:0] REG_LEVEL     = 3'd2;
   localparam logic [2:0] REG_WIDTH     = 3'd3;
   localparam logic [2:0] REG_HEIGHT    = 3'd4;

   typedef struct packed {
      logic               valid;
      logic [2:0]         status;
      logic               aa;
      logic [ADDR_W-1:0]  row;
      logic [ADDR_W-1:0]  col;
      logic [OPND_W-1:0]  byp_r;
      logic [OPND_W-1:0]  byp_g;
      logic [OPND_W-1:0]  byp_b;
   } side_type;
endpackage

// ----- rtl/gpr_div_cell.sv -----
`timescale 1ns / 1ps
// One restoring division cell: produces one quotient bit per cycle.
// Depends on gpr_pkg.
module gpr_div_cell import gpr_pkg::*; (
   input  logic               clock,
   input  logic [COUNT_W-1:0] divisor,
   input  logic [DQ_W-1:0]    dq_in,
   input  logic [COUNT_W-1:0] rem_in,
   output logic [DQ_W-1:0]    dq_out,
   output logic [COUNT_W-1:0] rem_out
);
   logic [COUNT_W:0]   trial;
   logic               ge;
   logic [COUNT_W:0]   diff;
   logic [DQ_W-1:0]    dq_ff, dq_next_in;
   logic [COUNT_W-1:0] rem_ff, rem_next_in;

   always_comb begin
      trial       = {rem_in, dq_in[DQ_W-1]};
      ge          = trial >= {1'b0, divisor};
      diff        = trial - {1'b0, divisor};
      rem_next_in = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      dq_next_in  = {dq_in[DQ_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_next_in;
      rem_ff <= rem_next_in;
   end

   assign dq_out  = dq_ff;
   assign rem_out = rem_ff;
endmodule

// ----- rtl/gpr_sqrt_cell.sv -----
`timescale 1ns / 1ps
// One digit-recurrence square root cell: one root bit per cycle.
// Depends on gpr_pkg.
module gpr_sqrt_cell import gpr_pkg::*; (
   input  logic              clock,
   input  logic [DQ_W-1:0]   qv_in,
   input  logic [SREM_W-1:0] rem_in,
   input  logic [ROOT_W-1:0] root_in,
   output logic [DQ_W-1:0]   qv_out,
   output logic [SREM_W-1:0] rem_out,
   output logic [ROOT_W-1:0] root_out
);
   logic [SREM_W+1:0] t;
   logic [SREM_W+1:0] trial;
   logic [SREM_W+1:0] diff;
   logic              ge;
   logic [DQ_W-1:0]   qv_ff;
   logic [SREM_W-1:0] rem_ff, rem_next_in;
   logic [ROOT_W-1:0] root_ff;

   always_comb begin
      t           = {rem_in, qv_in[DQ_W-1:DQ_W-2]};
      trial       = {2'b00, root_in, 2'b01};
      ge          = t >= trial;
      diff        = t - trial;
      rem_next_in = ge ? diff[SREM_W-1:0] : t[SREM_W-1:0];
   end

   always_ff @(posedge clock) begin
      qv_ff   <= {qv_in[DQ_W-3:0], 2'b00};
      rem_ff  <= rem_next_in;
      root_ff <= {root_in[ROOT_W-2:0], (ge)};
   end

   assign qv_out   = qv_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
endmodule

// ----- rtl/gamma_pixel_resolve_core.sv -----
`timescale 1ns / 1ps
// Top level of the gamma pixel resolve core: position and range checks,
// divide and root chains of cells, scaling. Depends on gpr_pkg and the cells.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   request  | start / busy         | req_red_in, req_green_in, req_blue_in,
//            |                      | req_row_in, req_col_in
//   response | rsp_valid strobe     | rsp_status, rsp_write_enable, rsp_pixel_*,
//            |                      | rsp_*_level
//   csr      | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// One pixel is accepted every cycle; busy is never raised. Each transfer
// passes through 44 divider cells (one quotient bit each), 22 root cells
// (one root bit each), a clamp register, a multiply register and the output
// register. Reset clears the configuration and the valid bits of the
// pipeline. The receiver cannot stall; every result is shown for exactly
// one cycle under rsp_valid.
module gamma_pixel_resolve_core import gpr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COMP_W-1:0]  req_red_in,
   input  logic signed [COMP_W-1:0]  req_green_in,
   input  logic signed [COMP_W-1:0]  req_blue_in,
   input  logic signed [POS_W-1:0]   req_row_in,
   input  logic signed [POS_W-1:0]   req_col_in,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_status,
   output logic                      rsp_write_enable,
   output logic [ADDR_W-1:0]         rsp_pixel_row,
   output logic [ADDR_W-1:0]         rsp_pixel_col,
   output logic [LEVEL_W-1:0]        rsp_red_level,
   output logic [LEVEL_W-1:0]        rsp_green_level,
   output logic [LEVEL_W-1:0]        rsp_blue_level,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [4:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   // Configuration registers.
   logic               antialias_ff;
   logic [COUNT_W-1:0] samples_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [DIM_W-1:0]   width_ff, height_ff;
   logic               csr_write;
   logic [2:0]         csr_index;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         antialias_ff <= 1'b0;
         samples_ff   <= 11'd1;
         level_ff     <= 16'd255;
         width_ff     <= 13'd256;
         height_ff    <= 13'd256;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ANTIALIAS: antialias_ff <= pwdata[0];
            REG_SAMPLES:   samples_ff   <= pwdata[COUNT_W-1:0];
            REG_LEVEL:     level_ff     <= pwdata[LEVEL_W-1:0];
            REG_WIDTH:     width_ff     <= pwdata[DIM_W-1:0];
            REG_HEIGHT:    height_ff    <= pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ANTIALIAS: prdata = {31'd0, antialias_ff};
         REG_SAMPLES:   prdata = {{(32-COUNT_W){1'b0}}, samples_ff};
         REG_LEVEL:     prdata = {{(32-LEVEL_W){1'b0}}, level_ff};
         REG_WIDTH:     prdata = {{(32-DIM_W){1'b0}}, width_ff};
         REG_HEIGHT:    prdata = {{(32-DIM_W){1'b0}}, height_ff};
         default:       prdata = 32'd0;
      endcase
   end

   // Entry checks. The image limits are capped at the frame store size and
   // a zero sample count divides by one.
   logic [DIM_W-1:0]   hmax, wmax;
   logic [COUNT_W-1:0] divisor;
   logic               outside;
   logic [2:0]         lane_bad;
   logic [COMP_W-1:0]  comp [3];
   side_type           entry;

   assign comp[0] = req_red_in;
   assign comp[1] = req_green_in;
   assign comp[2] = req_blue_in;
   assign divisor = (samples_ff == '0) ? 11'd1 : samples_ff;

   always_comb begin
      hmax    = (height_ff < MAX_DIM) ? height_ff : MAX_DIM;
      wmax    = (width_ff < MAX_DIM) ? width_ff : MAX_DIM;
      outside = req_row_in[POS_W-1] | req_col_in[POS_W-1]
              | ({1'b0, req_row_in[ADDR_W-1:0]} >= hmax)
              | ({1'b0, req_col_in[ADDR_W-1:0]} >= wmax);
      for (int i = 0; i < 3; i++) begin
         lane_bad[i] = comp[i][COMP_W-1]
                     | (comp[i] > {{(COMP_W-OPND_W){1'b0}}, ONE_FX});
      end
      entry.valid = start;
      entry.aa    = antialias_ff;
      entry.row   = req_row_in[ADDR_W-1:0];
      entry.col   = req_col_in[ADDR_W-1:0];
      entry.byp_r = comp[0][OPND_W-1:0];
      entry.byp_g = comp[1][OPND_W-1:0];
      entry.byp_b = comp[2][OPND_W-1:0];
      priority if (outside)                    entry.status = ST_OUT;
      else if (!antialias_ff && lane_bad[0])   entry.status = ST_RED;
      else if (!antialias_ff && lane_bad[1])   entry.status = ST_GREEN;
      else if (!antialias_ff && lane_bad[2])   entry.status = ST_BLUE;
      else                                     entry.status = ST_OK;
   end

   // Side pipeline that travels alongside the cells; stage k matches the
   // output of cell k.
   side_type side_ff [CHAIN_LEN];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CHAIN_LEN; k++) side_ff[k] <= '0;
      end else begin
         side_ff[0] <= entry;
         for (int k = 1; k < CHAIN_LEN; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // Three lanes, each a divider chain followed by a root chain. A sum that
   // is zero or negative enters as zero and comes out as a zero root.
   logic [ROOT_W-1:0] root_w [3];

   for (genvar ln = 0; ln < 3; ln++) begin : g_lane
      logic [DQ_W-1:0]    dq_w   [DIV_STEPS + 1];
      logic [COUNT_W-1:0] drem_w [DIV_STEPS + 1];
      logic [DQ_W-1:0]    qv_w   [SQRT_STEPS + 1];
      logic [SREM_W-1:0]  srem_w [SQRT_STEPS + 1];
      logic [ROOT_W-1:0]  rt_w   [SQRT_STEPS + 1];

      assign dq_w[0]   = comp[ln][COMP_W-1] ? '0 : {comp[ln], {FRAC_BITS{1'b0}}};
      assign drem_w[0] = '0;

      for (genvar c = 0; c < DIV_STEPS; c++) begin : g_div
         gpr_div_cell u_div (
            .clock   (clock),
            .divisor (divisor),
            .dq_in   (dq_w[c]),
            .rem_in  (drem_w[c]),
            .dq_out  (dq_w[c+1]),
            .rem_out (drem_w[c+1])
         );
      end

      assign qv_w[0]   = dq_w[DIV_STEPS];
      assign srem_w[0] = '0;
      assign rt_w[0]   = '0;

      for (genvar c = 0; c < SQRT_STEPS; c++) begin : g_sqrt
         gpr_sqrt_cell u_sqrt (
            .clock    (clock),
            .qv_in    (qv_w[c]),
            .rem_in   (srem_w[c]),
            .root_in  (rt_w[c]),
            .qv_out   (qv_w[c+1]),
            .rem_out  (srem_w[c+1]),
            .root_out (rt_w[c+1])
         );
      end

      assign root_w[ln] = rt_w[SQRT_STEPS];
   end

   // Clamp stage: the root is capped in antialias mode, the raw value is
   // used in range-check mode. The last side stage lines up with the root.
   side_type          clamp_side_ff, mult_side_ff;
   logic [OPND_W-1:0] opnd_ff [3];
   logic [OPND_W-1:0] byp [3];
   logic [PROD_W-1:0] prod_ff [3];

   assign byp[0] = side_ff[CHAIN_LEN-1].byp_r;
   assign byp[1] = side_ff[CHAIN_LEN-1].byp_g;
   assign byp[2] = side_ff[CHAIN_LEN-1].byp_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_side_ff <= '0;
         mult_side_ff  <= '0;
      end else begin
         clamp_side_ff <= side_ff[CHAIN_LEN-1];
         mult_side_ff  <= clamp_side_ff;
      end
      for (int i = 0; i < 3; i++) begin
         if (!side_ff[CHAIN_LEN-1].aa) begin
            opnd_ff[i] <= byp[i];
         end else if (root_w[i] > {{(ROOT_W-OPND_W){1'b0}}, CLAMP_TOP}) begin
            opnd_ff[i] <= CLAMP_TOP;
         end else begin
            opnd_ff[i] <= root_w[i][OPND_W-1:0];
         end
         prod_ff[i] <= {{OPND_W{1'b0}}, level_ff} * {{LEVEL_W{1'b0}}, opnd_ff[i]};
      end
   end

   // Output register; a rejected write shows zeros on every address and level.
   logic               ok;
   logic               valid_ff;
   logic [2:0]         status_ff;
   logic               we_ff;
   logic [ADDR_W-1:0]  row_ff, col_ff;
   logic [LEVEL_W-1:0] lvl_ff [3];

   assign ok = (mult_side_ff.status == ST_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= mult_side_ff.valid;
      end
      status_ff <= mult_side_ff.status;
      we_ff     <= ok;
      row_ff    <= ok ? mult_side_ff.row : '0;
      col_ff    <= ok ? mult_side_ff.col : '0;
      for (int i = 0; i < 3; i++) begin
         lvl_ff[i] <= ok ? prod_ff[i][FRAC_BITS +: LEVEL_W] : '0;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_pixel_row    = row_ff;
   assign rsp_pixel_col    = col_ff;
   assign rsp_red_level    = lvl_ff[0];
   assign rsp_green_level  = lvl_ff[1];
   assign rsp_blue_level   = lvl_ff[2];
endmodule
